>>> hw/rtl/cdt_pkg.sv
// ----------------------------------------------------------------------------
// cdt_pkg
// Shared types, widths, calendar constants and leap-year helpers for the
// calendar date-time adder.
// ----------------------------------------------------------------------------
package cdt_pkg;

  localparam int MAX_YEAR = 9999;

  localparam int KIND_W    = 3;
  localparam int AMOUNT_W  = 31;
  localparam int YEAR_W    = 14;
  localparam int MONTH_W   = 4;
  localparam int DAY_W     = 5;
  localparam int HOUR_W    = 5;
  localparam int MIN_W     = 6;
  localparam int SEC_W     = 6;
  localparam int ELAPSED_W = 40;

  // shared divider: 32-bit dividend, constant divisor up to 400
  localparam int DIV_W     = 32;
  localparam int DIVISOR_W = 9;

  localparam int SEC_PER_MIN      = 60;
  localparam int MIN_PER_HOUR     = 60;
  localparam int HOUR_PER_DAY     = 24;
  localparam int MON_PER_YEAR     = 12;
  localparam int SEC_PER_HOUR     = SEC_PER_MIN * MIN_PER_HOUR;
  localparam int SEC_PER_DAY      = SEC_PER_HOUR * HOUR_PER_DAY;
  localparam int DAYS_PER_YEAR    = 365;
  localparam int GREG_CYCLE_YEARS = 400;
  localparam int GREG_CYCLE_DAYS  = 146097;

  // a day count above this can never land inside the year range
  localparam int DAYS_LIMIT = (MAX_YEAR + 1) * 372;
  localparam int DAY_CNT_W  = $clog2(DAYS_LIMIT + 1);
  localparam int POS_W      = $clog2(MAX_YEAR * 366 + 1);
  localparam int TOD_W      = $clog2(SEC_PER_DAY);

  localparam logic [KIND_W-1:0] KIND_LOAD  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SEC   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_MIN   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_HOUR  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DAY   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_MONTH = 3'd5;
  localparam logic [KIND_W-1:0] KIND_YEAR  = 3'd6;
  localparam logic [KIND_W-1:0] KIND_DIFF  = 3'd7;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [AMOUNT_W-1:0] amount;
    logic [YEAR_W-1:0]   target_year;
    logic [MONTH_W-1:0]  target_month;
    logic [DAY_W-1:0]    target_day;
    logic [HOUR_W-1:0]   target_hour;
    logic [MIN_W-1:0]    target_minute;
    logic [SEC_W-1:0]    target_second;
  } cdt_req_t;

  typedef struct packed {
    logic [YEAR_W-1:0]    cur_year;
    logic [MONTH_W-1:0]   cur_month;
    logic [DAY_W-1:0]     cur_day;
    logic [HOUR_W-1:0]    cur_hour;
    logic [MIN_W-1:0]     cur_minute;
    logic [SEC_W-1:0]     cur_second;
    logic [ELAPSED_W-1:0] elapsed_seconds;
    logic                 error;
  } cdt_rsp_t;

  typedef struct packed {
    logic done;
    logic ovf;
  } cdt_walk_sts_t;

  // leap test from the two low year bits and the year modulo 400
  function automatic logic is_leap(input logic [1:0] ylo, input logic [DIVISOR_W-1:0] r400);
    logic century;
    century = (r400 == 9'd0) || (r400 == 9'd100) || (r400 == 9'd200) || (r400 == 9'd300);
    return ((ylo == 2'd0) && !century) || (r400 == 9'd0);
  endfunction

  // year modulo 400 of the following year
  function automatic logic [DIVISOR_W-1:0] r400_inc(input logic [DIVISOR_W-1:0] r400);
    return (r400 == DIVISOR_W'(GREG_CYCLE_YEARS - 1)) ? '0 : r400 + DIVISOR_W'(1);
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m, input logic leap);
    logic [DAY_W-1:0] len;
    unique case (m) inside
      4'd2:                                    len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:                 len = 5'd30;
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      default:                                 len = 5'd30;
    endcase
    return len;
  endfunction

  // days before the first of month m in a common year
  function automatic logic [8:0] month_cum(input logic [MONTH_W-1:0] m);
    logic [8:0] cum;
    unique case (m)
      4'd2:    cum = 9'd31;
      4'd3:    cum = 9'd59;
      4'd4:    cum = 9'd90;
      4'd5:    cum = 9'd120;
      4'd6:    cum = 9'd151;
      4'd7:    cum = 9'd181;
      4'd8:    cum = 9'd212;
      4'd9:    cum = 9'd243;
      4'd10:   cum = 9'd273;
      4'd11:   cum = 9'd304;
      4'd12:   cum = 9'd334;
      default: cum = 9'd0;
    endcase
    return cum;
  endfunction

endpackage

>>> hw/rtl/cdt_div.sv
// ----------------------------------------------------------------------------
// cdt_div
// Constant divider for the calendar's few divisors: reciprocal multiply,
// back-multiply and one correcting subtract, each registered in its own phase after go.
// ----------------------------------------------------------------------------
module cdt_div
  import cdt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 go,
  input  logic [DIV_W-1:0]     dividend,
  input  logic [DIVISOR_W-1:0] divisor,
  output logic                 done,
  output logic [DIV_W-1:0]     quotient,
  output logic [DIVISOR_W-1:0] remainder
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_MUL  = 2'd1;
  localparam logic [1:0] PH_BACK = 2'd2;
  localparam logic [1:0] PH_FIX  = 2'd3;

  logic [1:0]           phase;
  logic [DIV_W-1:0]     num;
  logic [DIVISOR_W-1:0] dvsr;
  logic [DIV_W-1:0]     recip;
  logic [DIV_W-1:0]     q_est;
  logic [DIV_W-1:0]     back;
  logic [2*DIV_W-1:0]   prod;
  logic [DIV_W-1:0]     rest;
  logic                 fits;

  // floor(2^32 / d): the estimate is the true quotient or one below it;
  // minutes per hour share the seconds-per-minute entry
  function automatic logic [DIV_W-1:0] recip_of(input logic [DIVISOR_W-1:0] d);
    logic [DIV_W-1:0] r;
    unique case (d)
      DIVISOR_W'(SEC_PER_MIN):      r = DIV_W'((64'd1 << DIV_W) / SEC_PER_MIN);
      DIVISOR_W'(HOUR_PER_DAY):     r = DIV_W'((64'd1 << DIV_W) / HOUR_PER_DAY);
      DIVISOR_W'(MON_PER_YEAR):     r = DIV_W'((64'd1 << DIV_W) / MON_PER_YEAR);
      DIVISOR_W'(GREG_CYCLE_YEARS): r = DIV_W'((64'd1 << DIV_W) / GREG_CYCLE_YEARS);
      default:                      r = '0;
    endcase
    return r;
  endfunction

  assign prod = {{DIV_W{1'b0}}, num} * {{DIV_W{1'b0}}, recip};
  assign rest = num - back;
  assign fits = rest >= DIV_W'(dvsr);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (phase)
        PH_IDLE: begin
          if (go) begin
            num   <= dividend;
            dvsr  <= divisor;
            recip <= recip_of(divisor);
            phase <= PH_MUL;
          end
        end
        PH_MUL: begin
          q_est <= prod[2*DIV_W-1:DIV_W];
          phase <= PH_BACK;
        end
        PH_BACK: begin
          back  <= q_est * DIV_W'(dvsr);
          phase <= PH_FIX;
        end
        default: begin
          // the rest is below twice the divisor: one subtract settles it
          quotient  <= fits ? q_est + DIV_W'(1) : q_est;
          remainder <= fits ? DIVISOR_W'(rest - DIV_W'(dvsr)) : DIVISOR_W'(rest);
          done      <= 1'b1;
          phase     <= PH_IDLE;
        end
      endcase
    end
  end

  a_known_divisor: assert property (@(posedge clk) disable iff (rst)
    go |-> (recip_of(divisor) != '0))
    else $error("divider started with an unsupported divisor");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    done |-> (remainder < dvsr))
    else $error("divider remainder reached the divisor");

endmodule

>>> hw/rtl/cdt_walk.sv
// ----------------------------------------------------------------------------
// cdt_walk
// Day-count carry walker: strips 400-year cycles, then whole years, then
// single months off a day count until it fits in the current month.
// ----------------------------------------------------------------------------
module cdt_walk
  import cdt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 go,
  input  logic [DAY_CNT_W-1:0] t_in,
  input  logic [YEAR_W-1:0]    y_in,
  input  logic [MONTH_W-1:0]   m_in,
  input  logic [DIVISOR_W-1:0] r400_in,
  output cdt_walk_sts_t        sts,
  output logic [YEAR_W-1:0]    y_out,
  output logic [MONTH_W-1:0]   m_out,
  output logic [DAY_W-1:0]     d_out
);

  localparam logic [1:0] MODE_CYCLE = 2'd0;
  localparam logic [1:0] MODE_YEAR  = 2'd1;
  localparam logic [1:0] MODE_MONTH = 2'd2;

  logic                 run;
  logic [1:0]           mode;
  logic [DAY_CNT_W-1:0] t;
  logic [YEAR_W-1:0]    y;
  logic [MONTH_W-1:0]   m;
  logic [DIVISOR_W-1:0] r400;

  logic                 leap_now;
  logic                 leap_up;
  logic [DIVISOR_W-1:0] r400_up;
  logic [YEAR_W-1:0]    y_up;
  logic [DAY_W-1:0]     mlen;
  logic [DAY_CNT_W-1:0] ylen;
  logic [DAY_CNT_W-1:0] step;
  logic                 allow;
  logic                 take;

  assign leap_now = is_leap(y[1:0], r400);
  assign r400_up  = r400_inc(r400);
  assign y_up     = y + YEAR_W'(1);
  assign leap_up  = is_leap(y_up[1:0], r400_up);
  assign mlen     = month_len(m, leap_now);
  // twelve months from m: February of this year or of the next one
  assign ylen     = DAY_CNT_W'(DAYS_PER_YEAR)
                  + DAY_CNT_W'((m <= 4'd2) ? leap_now : leap_up);

  always_comb begin
    unique case (mode)
      MODE_CYCLE: begin
        step  = DAY_CNT_W'(GREG_CYCLE_DAYS);
        allow = y <= YEAR_W'(MAX_YEAR - GREG_CYCLE_YEARS);
      end
      MODE_YEAR: begin
        step  = ylen;
        allow = y < YEAR_W'(MAX_YEAR);
      end
      default: begin
        step  = DAY_CNT_W'(mlen);
        allow = 1'b1;
      end
    endcase
  end

  assign take = allow && (t > step);

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      sts <= '0;
    end else begin
      sts <= '0;
      if (go) begin
        run  <= 1'b1;
        mode <= MODE_CYCLE;
        t    <= t_in;
        y    <= y_in;
        m    <= m_in;
        r400 <= r400_in;
      end else if (run) begin
        if (take) begin
          t <= t - step;
          unique case (mode)
            MODE_CYCLE: y <= y + YEAR_W'(GREG_CYCLE_YEARS);
            MODE_YEAR: begin
              y    <= y_up;
              r400 <= r400_up;
            end
            default: begin
              if (m == MONTH_W'(MON_PER_YEAR)) begin
                if (y == YEAR_W'(MAX_YEAR)) begin
                  run      <= 1'b0;
                  sts.done <= 1'b1;
                  sts.ovf  <= 1'b1;
                end else begin
                  m    <= MONTH_W'(1);
                  y    <= y_up;
                  r400 <= r400_up;
                end
              end else begin
                m <= m + MONTH_W'(1);
              end
            end
          endcase
        end else if (mode == MODE_CYCLE) begin
          mode <= MODE_YEAR;
        end else if (mode == MODE_YEAR) begin
          mode <= MODE_MONTH;
        end else begin
          run      <= 1'b0;
          sts.done <= 1'b1;
        end
      end
    end
  end

  assign y_out = y;
  assign m_out = m;
  assign d_out = t[DAY_W-1:0];

  a_count_positive: assert property (@(posedge clk) disable iff (rst)
    run |-> (t != '0))
    else $error("walker day count reached zero");

  a_year_in_range: assert property (@(posedge clk) disable iff (rst)
    run |-> (y <= YEAR_W'(MAX_YEAR)))
    else $error("walker year passed the upper limit");

endmodule

>>> hw/rtl/calendar_datetime_adder.sv
// ----------------------------------------------------------------------------
// calendar_datetime_adder
// Keeps one Gregorian date-time and applies one request at a time: load,
// add seconds, minutes, hours, days, months or years, or count the seconds
// forward to a target. Raise start with a request while busy is low; the
// request is taken on that edge and busy stays high until the result. The
// result appears on result for exactly one cycle with done high and must be
// captured then, since there is no way to hold it off. Every carry through
// seconds, minutes, hours and the year modulo 400 goes through one shared
// constant divider (reciprocal multiply, back-multiply, one correcting
// subtract), and a day carry then walks 400-year cycles, whole years and
// single months one per cycle. error flags an invalid, earlier or
// same-position target (state untouched) or a year carry past the limit,
// which saturates the stored date-time to the last second of the last year.
// Months add without clamping the day, so a day past its month's end may be
// stored; it carries on linearly on the next forward step.
// ----------------------------------------------------------------------------
module calendar_datetime_adder
  import cdt_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  cdt_req_t request,
  output logic     done,
  output cdt_rsp_t result
);

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_SEC    = 5'd1;
  localparam logic [4:0] ST_MIN    = 5'd2;
  localparam logic [4:0] ST_HOUR   = 5'd3;
  localparam logic [4:0] ST_DAYCHK = 5'd4;
  localparam logic [4:0] ST_YDIV   = 5'd5;
  localparam logic [4:0] ST_WALK   = 5'd6;
  localparam logic [4:0] ST_MON    = 5'd7;
  localparam logic [4:0] ST_YEAR   = 5'd8;
  localparam logic [4:0] ST_TDIV   = 5'd9;
  localparam logic [4:0] ST_PMUL   = 5'd10;
  localparam logic [4:0] ST_PSUM   = 5'd11;
  localparam logic [4:0] ST_CDIV   = 5'd12;
  localparam logic [4:0] ST_DIFF   = 5'd13;
  localparam logic [4:0] ST_DMUL   = 5'd14;
  localparam logic [4:0] ST_DADD   = 5'd15;
  localparam logic [4:0] ST_DONE   = 5'd16;

  logic [4:0] state;
  cdt_req_t   req;

  // stored date-time
  logic [YEAR_W-1:0]  year;
  logic [MONTH_W-1:0] month;
  logic [DAY_W-1:0]   day;
  logic [HOUR_W-1:0]  hour;
  logic [MIN_W-1:0]   minute;
  logic [SEC_W-1:0]   second;

  logic                 err;
  logic [ELAPSED_W-1:0] elapsed;
  logic [DIV_W-1:0]     acc;
  logic [TOD_W-1:0]     tgt_tod;
  logic [TOD_W-1:0]     cur_tod;

  // day position operands, shared by target and stored date
  logic [YEAR_W-1:0]    pos_p;
  logic [YEAR_W-1:0]    pos_q;
  logic [DIVISOR_W-1:0] pos_r;
  logic [MONTH_W-1:0]   pos_m;
  logic [DAY_W-1:0]     pos_d;
  logic                 pos_sel;
  logic [POS_W-1:0]     prod;
  logic [POS_W-1:0]     tp;
  logic [POS_W-1:0]     cp;
  logic [POS_W-1:0]     ddays;

  // shared divider
  logic                 div_go;
  logic [DIV_W-1:0]     div_a;
  logic [DIVISOR_W-1:0] div_b;
  logic                 div_done;
  logic [DIV_W-1:0]     div_q;
  logic [DIVISOR_W-1:0] div_r;

  // day carry walker
  logic                 walk_go;
  logic [DAY_CNT_W-1:0] walk_t;
  cdt_walk_sts_t        walk_sts;
  logic [YEAR_W-1:0]    walk_y;
  logic [MONTH_W-1:0]   walk_m;
  logic [DAY_W-1:0]     walk_d;

  logic [DIV_W-1:0]     day_sum;
  logic [DIV_W-1:0]     mon_year;
  logic [DIV_W-1:0]     amt_year;
  logic                 t_leap;
  logic                 t_valid;
  logic                 same_date;
  logic                 ps_leap;
  logic [1:0]           ps_cent;
  logic [POS_W-1:0]     psum;
  logic                 add_kind;

  function automatic logic [1:0] cent_of(input logic [DIVISOR_W-1:0] r);
    return (r >= 9'd300) ? 2'd3 : (r >= 9'd200) ? 2'd2 : (r >= 9'd100) ? 2'd1 : 2'd0;
  endfunction

  cdt_div u_div (
    .clk       (clk),
    .rst       (rst),
    .go        (div_go),
    .dividend  (div_a),
    .divisor   (div_b),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  cdt_walk u_walk (
    .clk     (clk),
    .rst     (rst),
    .go      (walk_go),
    .t_in    (walk_t),
    .y_in    (year),
    .m_in    (month),
    .r400_in (div_r),
    .sts     (walk_sts),
    .y_out   (walk_y),
    .m_out   (walk_m),
    .d_out   (walk_d)
  );

  assign busy     = (state != ST_IDLE);
  assign add_kind = (req.kind != KIND_LOAD) && (req.kind != KIND_DIFF);

  assign day_sum  = acc + DIV_W'(day);
  assign mon_year = DIV_W'(year) + div_q;
  assign amt_year = DIV_W'(year) + DIV_W'(req.amount);

  // target checks; the divider holds (target_year - 1) / 400
  assign t_leap  = is_leap(req.target_year[1:0], r400_inc(div_r));
  assign t_valid = (req.target_year != '0)
                && (req.target_year <= YEAR_W'(MAX_YEAR))
                && (req.target_month != '0)
                && (req.target_month <= MONTH_W'(MON_PER_YEAR))
                && (req.target_day != '0)
                && (req.target_day <= month_len(req.target_month, t_leap))
                && (req.target_hour < HOUR_W'(HOUR_PER_DAY))
                && (req.target_minute < MIN_W'(MIN_PER_HOUR))
                && (req.target_second < SEC_W'(SEC_PER_MIN));
  assign same_date = (req.target_year == year) && (req.target_month == month)
                  && (req.target_day == day);

  // linear day number; pos_p is year - 1, pos_q/pos_r its quotient/rest by 400
  assign ps_leap = is_leap(pos_p[1:0] + 2'd1, r400_inc(pos_r));
  assign ps_cent = cent_of(pos_r);
  assign psum    = prod + POS_W'(pos_p >> 2)
                 - (POS_W'(pos_q) << 2) - POS_W'(ps_cent) + POS_W'(pos_q)
                 + POS_W'(month_cum(pos_m))
                 + POS_W'((pos_m > 4'd2) && ps_leap)
                 + POS_W'(pos_d) - POS_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      done    <= 1'b0;
      div_go  <= 1'b0;
      walk_go <= 1'b0;
      year    <= YEAR_W'(1);
      month   <= MONTH_W'(1);
      day     <= DAY_W'(1);
      hour    <= '0;
      minute  <= '0;
      second  <= '0;
    end else begin
      done    <= 1'b0;
      div_go  <= 1'b0;
      walk_go <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            req     <= request;
            err     <= 1'b0;
            elapsed <= '0;
            tgt_tod <= TOD_W'(request.target_hour) * TOD_W'(SEC_PER_HOUR)
                     + TOD_W'(request.target_minute) * TOD_W'(SEC_PER_MIN)
                     + TOD_W'(request.target_second);
            cur_tod <= TOD_W'(hour) * TOD_W'(SEC_PER_HOUR)
                     + TOD_W'(minute) * TOD_W'(SEC_PER_MIN) + TOD_W'(second);
            unique case (request.kind) inside
              KIND_LOAD, KIND_DIFF: begin
                div_go <= 1'b1;
                div_a  <= DIV_W'(request.target_year) - DIV_W'(1);
                div_b  <= DIVISOR_W'(GREG_CYCLE_YEARS);
                state  <= ST_TDIV;
              end
              KIND_SEC: begin
                div_go <= 1'b1;
                div_a  <= DIV_W'(second) + DIV_W'(request.amount);
                div_b  <= DIVISOR_W'(SEC_PER_MIN);
                state  <= ST_SEC;
              end
              KIND_MIN: begin
                div_go <= 1'b1;
                div_a  <= DIV_W'(minute) + DIV_W'(request.amount);
                div_b  <= DIVISOR_W'(MIN_PER_HOUR);
                state  <= ST_MIN;
              end
              KIND_HOUR: begin
                div_go <= 1'b1;
                div_a  <= DIV_W'(hour) + DIV_W'(request.amount);
                div_b  <= DIVISOR_W'(HOUR_PER_DAY);
                state  <= ST_HOUR;
              end
              KIND_DAY: begin
                acc   <= DIV_W'(request.amount);
                state <= ST_DAYCHK;
              end
              KIND_MONTH: begin
                div_go <= 1'b1;
                div_a  <= DIV_W'(month) - DIV_W'(1) + DIV_W'(request.amount);
                div_b  <= DIVISOR_W'(MON_PER_YEAR);
                state  <= ST_MON;
              end
              default: state <= ST_YEAR;
            endcase
          end
        end
        // carry chain: keep the remainder, pass the quotient upward
        ST_SEC: begin
          if (div_done) begin
            second <= div_r[SEC_W-1:0];
            div_go <= 1'b1;
            div_a  <= DIV_W'(minute) + div_q;
            div_b  <= DIVISOR_W'(MIN_PER_HOUR);
            state  <= ST_MIN;
          end
        end
        ST_MIN: begin
          if (div_done) begin
            minute <= div_r[MIN_W-1:0];
            div_go <= 1'b1;
            div_a  <= DIV_W'(hour) + div_q;
            div_b  <= DIVISOR_W'(HOUR_PER_DAY);
            state  <= ST_HOUR;
          end
        end
        ST_HOUR: begin
          if (div_done) begin
            hour  <= div_r[HOUR_W-1:0];
            acc   <= div_q;
            state <= ST_DAYCHK;
          end
        end
        ST_DAYCHK: begin
          if (day_sum > DIV_W'(DAYS_LIMIT)) begin
            err   <= 1'b1;
            state <= ST_DONE;
          end else begin
            // the walker needs the year modulo 400 for leap tests
            walk_t <= day_sum[DAY_CNT_W-1:0];
            div_go <= 1'b1;
            div_a  <= DIV_W'(year);
            div_b  <= DIVISOR_W'(GREG_CYCLE_YEARS);
            state  <= ST_YDIV;
          end
        end
        ST_YDIV: begin
          if (div_done) begin
            walk_go <= 1'b1;
            state   <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (walk_sts.done) begin
            if (walk_sts.ovf) begin
              err <= 1'b1;
            end else begin
              year  <= walk_y;
              month <= walk_m;
              day   <= walk_d;
            end
            state <= ST_DONE;
          end
        end
        ST_MON: begin
          if (div_done) begin
            if (mon_year > DIV_W'(MAX_YEAR)) begin
              err <= 1'b1;
            end else begin
              year  <= mon_year[YEAR_W-1:0];
              month <= div_r[MONTH_W-1:0] + MONTH_W'(1);
            end
            state <= ST_DONE;
          end
        end
        ST_YEAR: begin
          if (amt_year > DIV_W'(MAX_YEAR)) begin
            err <= 1'b1;
          end else begin
            year <= amt_year[YEAR_W-1:0];
          end
          state <= ST_DONE;
        end
        ST_TDIV: begin
          if (div_done) begin
            if (!t_valid) begin
              err   <= 1'b1;
              state <= ST_DONE;
            end else if (req.kind == KIND_LOAD) begin
              year   <= req.target_year;
              month  <= req.target_month;
              day    <= req.target_day;
              hour   <= req.target_hour;
              minute <= req.target_minute;
              second <= req.target_second;
              state  <= ST_DONE;
            end else if (same_date) begin
              if (tgt_tod >= cur_tod) begin
                elapsed <= ELAPSED_W'(tgt_tod - cur_tod);
              end else begin
                err <= 1'b1;
              end
              state <= ST_DONE;
            end else begin
              pos_p   <= req.target_year - YEAR_W'(1);
              pos_q   <= div_q[YEAR_W-1:0];
              pos_r   <= div_r;
              pos_m   <= req.target_month;
              pos_d   <= req.target_day;
              pos_sel <= 1'b0;
              state   <= ST_PMUL;
            end
          end
        end
        ST_PMUL: begin
          prod  <= POS_W'(pos_p) * POS_W'(DAYS_PER_YEAR);
          state <= ST_PSUM;
        end
        ST_PSUM: begin
          if (!pos_sel) begin
            tp     <= psum;
            div_go <= 1'b1;
            div_a  <= DIV_W'(year) - DIV_W'(1);
            div_b  <= DIVISOR_W'(GREG_CYCLE_YEARS);
            state  <= ST_CDIV;
          end else begin
            cp    <= psum;
            state <= ST_DIFF;
          end
        end
        ST_CDIV: begin
          if (div_done) begin
            pos_p   <= year - YEAR_W'(1);
            pos_q   <= div_q[YEAR_W-1:0];
            pos_r   <= div_r;
            pos_m   <= month;
            pos_d   <= day;
            pos_sel <= 1'b1;
            state   <= ST_PMUL;
          end
        end
        ST_DIFF: begin
          // an over-long stored day can share the target's position: flagged as an error
          if (tp > cp) begin
            ddays <= tp - cp;
            state <= ST_DMUL;
          end else begin
            err   <= 1'b1;
            state <= ST_DONE;
          end
        end
        ST_DMUL: begin
          elapsed <= ELAPSED_W'(ddays) * ELAPSED_W'(SEC_PER_DAY);
          state   <= ST_DADD;
        end
        ST_DADD: begin
          elapsed <= elapsed + ELAPSED_W'(tgt_tod) - ELAPSED_W'(cur_tod);
          state   <= ST_DONE;
        end
        ST_DONE: begin
          done                   <= 1'b1;
          result.error           <= err;
          result.elapsed_seconds <= err ? '0 : elapsed;
          if (err && add_kind) begin
            // year carry overflow: saturate to the last representable second
            year              <= YEAR_W'(MAX_YEAR);
            month             <= MONTH_W'(MON_PER_YEAR);
            day               <= DAY_W'(31);
            hour              <= HOUR_W'(HOUR_PER_DAY - 1);
            minute            <= MIN_W'(MIN_PER_HOUR - 1);
            second            <= SEC_W'(SEC_PER_MIN - 1);
            result.cur_year   <= YEAR_W'(MAX_YEAR);
            result.cur_month  <= MONTH_W'(MON_PER_YEAR);
            result.cur_day    <= DAY_W'(31);
            result.cur_hour   <= HOUR_W'(HOUR_PER_DAY - 1);
            result.cur_minute <= MIN_W'(MIN_PER_HOUR - 1);
            result.cur_second <= SEC_W'(SEC_PER_MIN - 1);
          end else begin
            result.cur_year   <= year;
            result.cur_month  <= month;
            result.cur_day    <= day;
            result.cur_hour   <= hour;
            result.cur_minute <= minute;
            result.cur_second <= second;
          end
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_result_date_sane: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.cur_month >= MONTH_W'(1) && result.cur_month <= MONTH_W'(MON_PER_YEAR)
              && result.cur_year >= YEAR_W'(1) && result.cur_year <= YEAR_W'(MAX_YEAR)))
    else $error("result date outside the calendar range");

  a_error_clears_elapsed: assert property (@(posedge clk) disable iff (rst)
    (done && result.error) |-> (result.elapsed_seconds == '0))
    else $error("elapsed count reported together with an error");

endmodule

>>> test/calendar_datetime_adder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// calendar_datetime_adder testbench
// Drives load, add and difference requests through the start/busy handshake.
// It predicts each stored date-time, elapsed count and error flag in a local
// calendar model and compares every done-strobed result with the oldest
// prediction. A short directed list comes first, then a long random mix of
// well-formed and broken requests with random idle gaps between them.
// ----------------------------------------------------------------------------
module testbench;
  import cdt_pkg::*;

  localparam int RANDOM_REQUESTS = 1450;
  localparam int DRAIN_CYCLES    = 700;        // a bit over the slowest request
  localparam int LIMIT_CYCLES    = 4_000_000;  // several times the slowest run

  // Date-time kept by the predictor, at the block's field widths.
  typedef struct packed {
    logic [YEAR_W-1:0]  yr;
    logic [MONTH_W-1:0] mon;
    logic [DAY_W-1:0]   dy;
    logic [HOUR_W-1:0]  hr;
    logic [MIN_W-1:0]   mn;
    logic [SEC_W-1:0]   sc;
  } cal_state_t;

  localparam cal_state_t CAL_AT_RESET =
    '{yr: 1, mon: 1, dy: 1, hr: 0, mn: 0, sc: 0};
  localparam cal_state_t CAL_SATURATED =
    '{yr: MAX_YEAR, mon: 12, dy: 31, hr: 23, mn: 59, sc: 59};

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  cdt_req_t request = '0;
  logic     busy;
  logic     done;
  cdt_rsp_t result;

  cdt_req_t    queued_requests[$];   // stimulus waiting for the driver
  cdt_rsp_t    due_datetimes[$];     // predicted results, oldest first
  cal_state_t  plan_calendar = CAL_AT_RESET;  // tracks state while building stimulus
  cal_state_t  calendar_now = CAL_AT_RESET;   // tracks state of accepted requests

  int unsigned gap_left = 0;
  int unsigned calm_left = 0;
  int unsigned kind_seen[8];
  int unsigned overlong_seen = 0;
  int unsigned results_seen = 0;
  int unsigned errors_flagged = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  logic [ELAPSED_W-1:0] longest_span = '0;

  calendar_datetime_adder dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .request(request),
    .done   (done),
    .result (result)
  );

  always #2 clk = ~clk;

  // --------------------------------------------------------------------------
  // Calendar arithmetic
  // --------------------------------------------------------------------------
  function automatic bit leap_year(longint unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic longint unsigned days_in_month(longint unsigned m, longint unsigned y);
    longint unsigned len;
    case (m)
      2:                     len = leap_year(y) ? 29 : 28;
      4, 6, 9, 11:           len = 30;
      1, 3, 5, 7, 8, 10, 12: len = 31;
      default:               len = 30;
    endcase
    return len;
  endfunction

  // days before the first of month m in a common year
  function automatic longint unsigned days_before(longint unsigned m);
    longint unsigned cum;
    case (m)
      2:       cum = 31;
      3:       cum = 59;
      4:       cum = 90;
      5:       cum = 120;
      6:       cum = 151;
      7:       cum = 181;
      8:       cum = 212;
      9:       cum = 243;
      10:      cum = 273;
      11:      cum = 304;
      12:      cum = 334;
      default: cum = 0;
    endcase
    return cum;
  endfunction

  // Linear day number; an over-long day simply runs on past its month.
  function automatic longint unsigned day_index(longint unsigned y, m, d);
    longint unsigned p;
    p = y - 1;
    return p * 365 + p / 4 - p / 100 + p / 400 + days_before(m)
           + ((m > 2 && leap_year(y)) ? 1 : 0) + d - 1;
  endfunction

  function automatic bit date_ok(longint unsigned y, mo, d, h, mi, s);
    if (y < 1 || y > MAX_YEAR) return 1'b0;
    if (mo < 1 || mo > 12) return 1'b0;
    if (d < 1 || d > days_in_month(mo, y)) return 1'b0;
    return h <= 23 && mi <= 59 && s <= 59;
  endfunction

  // Each carry returns 1 when the year would pass MAX_YEAR.
  function automatic bit carry_days(inout cal_state_t st, input longint unsigned n);
    longint unsigned t, y, m;
    t = st.dy + n;
    y = st.yr;
    m = st.mon;
    if (t > (MAX_YEAR + 1) * 372) return 1'b1;
    while (t > days_in_month(m, y)) begin
      // skip a whole year at once from January; same result as month by month
      if (m == 1 && t > 365 + (leap_year(y) ? 1 : 0)) begin
        t -= 365 + (leap_year(y) ? 1 : 0);
        y++;
      end else begin
        t -= days_in_month(m, y);
        m++;
        if (m > 12) begin
          m = 1;
          y++;
        end
      end
      if (y > MAX_YEAR) return 1'b1;
    end
    st.yr  = YEAR_W'(y);
    st.mon = MONTH_W'(m);
    st.dy  = DAY_W'(t);
    return 1'b0;
  endfunction

  function automatic bit carry_hours(inout cal_state_t st, input longint unsigned n);
    longint unsigned t;
    t = st.hr + n;
    st.hr = HOUR_W'(t % 24);
    return carry_days(st, t / 24);
  endfunction

  function automatic bit carry_minutes(inout cal_state_t st, input longint unsigned n);
    longint unsigned t;
    t = st.mn + n;
    st.mn = MIN_W'(t % 60);
    return carry_hours(st, t / 60);
  endfunction

  function automatic bit carry_seconds(inout cal_state_t st, input longint unsigned n);
    longint unsigned t;
    t = st.sc + n;
    st.sc = SEC_W'(t % 60);
    return carry_minutes(st, t / 60);
  endfunction

  // Apply one request to st and return the result the block should give.
  function automatic cdt_rsp_t advance_calendar(inout cal_state_t st, input cdt_req_t rq);
    cdt_rsp_t rsp;
    bit fail;
    longint unsigned span, months, years, now_tod, tgt_tod, now_pos, tgt_pos;
    fail = 1'b0;
    span = 0;
    case (rq.kind)
      KIND_LOAD: begin
        if (date_ok(rq.target_year, rq.target_month, rq.target_day,
                    rq.target_hour, rq.target_minute, rq.target_second)) begin
          st = '{yr: rq.target_year, mon: rq.target_month, dy: rq.target_day,
                 hr: rq.target_hour, mn: rq.target_minute, sc: rq.target_second};
        end else begin
          fail = 1'b1;
        end
      end
      KIND_SEC:  fail = carry_seconds(st, rq.amount);
      KIND_MIN:  fail = carry_minutes(st, rq.amount);
      KIND_HOUR: fail = carry_hours(st, rq.amount);
      KIND_DAY:  fail = carry_days(st, rq.amount);
      KIND_MONTH: begin
        // no day clamp: the day is kept even past the new month's end
        months = st.mon - 1 + rq.amount;
        years = st.yr + months / 12;
        if (years > MAX_YEAR) begin
          fail = 1'b1;
        end else begin
          st.yr  = YEAR_W'(years);
          st.mon = MONTH_W'(months % 12 + 1);
        end
      end
      KIND_YEAR: begin
        years = st.yr + rq.amount;
        if (years > MAX_YEAR) fail = 1'b1;
        else st.yr = YEAR_W'(years);
      end
      default: begin
        now_tod = st.hr * 3600 + st.mn * 60 + st.sc;
        tgt_tod = rq.target_hour * 3600 + rq.target_minute * 60 + rq.target_second;
        if (!date_ok(rq.target_year, rq.target_month, rq.target_day,
                     rq.target_hour, rq.target_minute, rq.target_second)) begin
          fail = 1'b1;
        end else if (rq.target_year == st.yr && rq.target_month == st.mon &&
                     rq.target_day == st.dy) begin
          if (tgt_tod >= now_tod) span = tgt_tod - now_tod;
          else fail = 1'b1;
        end else begin
          // an over-long stored day on the target's position is a miss too
          now_pos = day_index(st.yr, st.mon, st.dy);
          tgt_pos = day_index(rq.target_year, rq.target_month, rq.target_day);
          if (tgt_pos > now_pos) span = (tgt_pos - now_pos) * 86400 + tgt_tod - now_tod;
          else fail = 1'b1;
        end
      end
    endcase
    if (fail && rq.kind != KIND_LOAD && rq.kind != KIND_DIFF) st = CAL_SATURATED;
    rsp.cur_year        = st.yr;
    rsp.cur_month       = st.mon;
    rsp.cur_day         = st.dy;
    rsp.cur_hour        = st.hr;
    rsp.cur_minute      = st.mn;
    rsp.cur_second      = st.sc;
    rsp.elapsed_seconds = fail ? '0 : ELAPSED_W'(span);
    rsp.error           = fail;
    return rsp;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus building
  // --------------------------------------------------------------------------

  // Every field random; fields a kind ignores stay that way.
  function automatic cdt_req_t noise_request();
    logic [95:0] raw;
    raw = {$urandom(), $urandom(), $urandom()};
    return raw[$bits(cdt_req_t)-1:0];
  endfunction

  task automatic set_target(inout cdt_req_t rq, input int unsigned y, mo, d, h, mi, s);
    rq.target_year   = YEAR_W'(y);
    rq.target_month  = MONTH_W'(mo);
    rq.target_day    = DAY_W'(d);
    rq.target_hour   = HOUR_W'(h);
    rq.target_minute = MIN_W'(mi);
    rq.target_second = SEC_W'(s);
  endtask

  // Valid date, leaning on the first and last years, centuries and month ends.
  task automatic pick_date(output int unsigned y, mo, d);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 15) y = $urandom_range(1, 12);
    else if (roll < 30) y = $urandom_range(MAX_YEAR - 12, MAX_YEAR);
    else if (roll < 40) y = 100 * $urandom_range(1, 99);
    else y = $urandom_range(1, MAX_YEAR);
    mo = $urandom_range(1, 12);
    if ($urandom_range(0, 3) == 0) d = days_in_month(mo, y);
    else d = $urandom_range(1, days_in_month(mo, y));
  endtask

  task automatic set_random_target(inout cdt_req_t rq);
    int unsigned y, mo, d;
    pick_date(y, mo, d);
    set_target(rq, y, mo, d, $urandom_range(0, 23), $urandom_range(0, 59),
               $urandom_range(0, 59));
  endtask

  // Push one field of a valid target out of range, or scramble all of them.
  task automatic break_target(inout cdt_req_t rq);
    logic [KIND_W-1:0] kind_keep;
    int unsigned len;
    len = days_in_month(rq.target_month, rq.target_year);
    case ($urandom_range(0, 6))
      0: rq.target_year = $urandom_range(0, 1) ? '0
                          : YEAR_W'($urandom_range(MAX_YEAR + 1, 2 ** YEAR_W - 1));
      1: rq.target_month = $urandom_range(0, 1) ? '0 : MONTH_W'($urandom_range(13, 15));
      2: rq.target_day = (len == 31 || $urandom_range(0, 1)) ? '0
                         : DAY_W'($urandom_range(len + 1, 31));
      3: rq.target_hour = HOUR_W'($urandom_range(24, 31));
      4: rq.target_minute = MIN_W'($urandom_range(60, 63));
      5: rq.target_second = SEC_W'($urandom_range(60, 63));
      default: begin
        kind_keep = rq.kind;
        rq = noise_request();
        rq.kind = kind_keep;
      end
    endcase
  endtask

  function automatic longint unsigned pick_amount();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return $urandom_range(0, 100);
    if (roll < 80) return $urandom_range(0, 100000);
    if (roll < 92) return $urandom() & 32'h7fff_ffff;
    case ($urandom_range(0, 6))
      0:       return 0;
      1:       return 1;
      2:       return 59;
      3:       return 60;
      4:       return 3599;
      5:       return 86399;
      default: return 2 ** AMOUNT_W - 1;
    endcase
  endfunction

  task automatic queue_request(cdt_req_t rq);
    queued_requests.push_back(rq);
    void'(advance_calendar(plan_calendar, rq));
  endtask

  task automatic plan_fixed(input logic [KIND_W-1:0] kind, input longint unsigned amount,
                            input int unsigned y, mo, d, h, mi, s);
    cdt_req_t rq;
    rq = noise_request();
    rq.kind = kind;
    if (kind == KIND_LOAD || kind == KIND_DIFF) set_target(rq, y, mo, d, h, mi, s);
    else rq.amount = AMOUNT_W'(amount);
    queue_request(rq);
  endtask

  task automatic plan_random_request();
    cdt_req_t   rq, step;
    cal_state_t probe;
    int unsigned roll;
    rq = noise_request();
    roll = $urandom_range(0, 99);
    // near the top of the year range most adds saturate: reload more often
    if (plan_calendar.yr > MAX_YEAR - 100 && $urandom_range(0, 1)) roll = 0;
    if (roll < 14) begin
      rq.kind = KIND_LOAD;
      set_random_target(rq);
    end else if (roll < 18) begin
      rq.kind = KIND_LOAD;
      set_random_target(rq);
      break_target(rq);
    end else if (roll < 58) begin
      rq.kind = KIND_W'($urandom_range(KIND_SEC, KIND_YEAR));
      rq.amount = AMOUNT_W'(pick_amount());
    end else if (roll < 88) begin
      // Reachable target: run a copy of the state forward and aim at it.
      // A zero step lands on the current time, or on the normalized date
      // when the stored day is over-long.
      probe = plan_calendar;
      step = noise_request();
      case ($urandom_range(0, 4))
        0: begin
          step.kind = KIND_SEC;
          step.amount = '0;
        end
        1: begin
          step.kind = KIND_SEC;
          step.amount = AMOUNT_W'($urandom_range(0, 86400));
        end
        2: begin
          step.kind = KIND_SEC;
          step.amount = AMOUNT_W'($urandom_range(0, 3_000_000));
        end
        3: begin
          step.kind = KIND_DAY;
          step.amount = AMOUNT_W'($urandom_range(0, 40000));
        end
        default: begin
          step.kind = KIND_DAY;
          step.amount = AMOUNT_W'($urandom_range(0, 3_700_000));
        end
      endcase
      void'(advance_calendar(probe, step));
      rq.kind = KIND_DIFF;
      set_target(rq, probe.yr, probe.mon, probe.dy, probe.hr, probe.mn, probe.sc);
      // sometimes keep the date but move the time of day either way
      if (roll >= 82) begin
        rq.target_hour   = HOUR_W'($urandom_range(0, 23));
        rq.target_minute = MIN_W'($urandom_range(0, 59));
        rq.target_second = SEC_W'($urandom_range(0, 59));
      end
    end else if (roll < 94) begin
      rq.kind = KIND_DIFF;
      set_random_target(rq);
    end else begin
      rq.kind = KIND_DIFF;
      set_random_target(rq);
      break_target(rq);
    end
    queue_request(rq);
  endtask

  // --------------------------------------------------------------------------
  // Driver: present the next request once the previous one was taken and its
  // idle gap has run out. start stays high across back-to-back requests.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    bit taken;
    bit hold;
    int unsigned roll;
    if (rst) begin
      start <= 1'b0;
      request <= '0;
      gap_left = 0;
      calm_left = 0;
      calendar_now = CAL_AT_RESET;
    end else begin
      taken = start && !busy;
      if (taken) begin
        due_datetimes.push_back(advance_calendar(calendar_now, request));
        kind_seen[request.kind]++;
        if (calendar_now.dy > days_in_month(calendar_now.mon, calendar_now.yr))
          overlong_seen++;
        // pick the idle gap before the next request: mostly short, a few
        // long enough to land past done, and now and then a calm stretch
        if (calm_left > 0) begin
          calm_left--;
          gap_left = 0;
        end else begin
          roll = $urandom_range(0, 99);
          if (roll < 4) begin
            calm_left = $urandom_range(20, 60);
            gap_left = 0;
          end else if (roll < 55) begin
            gap_left = $urandom_range(0, 2);
          end else if (roll < 93) begin
            gap_left = $urandom_range(3, 40);
          end else begin
            gap_left = $urandom_range(100, 700);
          end
        end
      end
      hold = start && !taken;
      if (!hold) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (queued_requests.size() != 0) begin
          request <= queued_requests.pop_front();
          hold = 1'b1;
        end
      end
      start <= hold;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: done marks a result for one cycle; match it with the oldest
  // prediction, field by field.
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    cdt_rsp_t want;
    if (!rst && done) begin
      if (due_datetimes.size() == 0) begin
        $display("%0t ns: result with no request outstanding, expected none, got %p",
                 $time, result);
        mismatches++;
      end else begin
        want = due_datetimes.pop_front();
        results_seen++;
        check_field("cur_year", want.cur_year, result.cur_year);
        check_field("cur_month", want.cur_month, result.cur_month);
        check_field("cur_day", want.cur_day, result.cur_day);
        check_field("cur_hour", want.cur_hour, result.cur_hour);
        check_field("cur_minute", want.cur_minute, result.cur_minute);
        check_field("cur_second", want.cur_second, result.cur_second);
        check_field("elapsed_seconds", want.elapsed_seconds, result.elapsed_seconds);
        check_field("error", want.error, result.error);
        if (want.error) errors_flagged++;
        if (want.elapsed_seconds > longest_span) longest_span = want.elapsed_seconds;
      end
    end
  end

  // Watchdog: drop the run if the block hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("cycle limit reached with %0d results outstanding", due_datetimes.size());
      $display("status: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus list, reset and end of run
  // --------------------------------------------------------------------------
  initial begin
    // Directed: extremes, every kind, and the calendar corner cases.
    plan_fixed(KIND_DIFF, 0, 1, 1, 1, 0, 0, 0);                 // equal to reset time
    plan_fixed(KIND_LOAD, 0, MAX_YEAR, 12, 31, 23, 59, 59);
    plan_fixed(KIND_SEC, 1, 0, 0, 0, 0, 0, 0);                  // carries past the last year
    plan_fixed(KIND_LOAD, 0, 2 ** YEAR_W - 1, 15, 31, 31, 63, 63);  // every field too big
    plan_fixed(KIND_LOAD, 0, 0, 1, 1, 0, 0, 0);                 // year zero
    plan_fixed(KIND_LOAD, 0, 1900, 2, 29, 0, 0, 0);             // century, not leap
    plan_fixed(KIND_LOAD, 0, 2000, 2, 29, 12, 0, 0);            // 400-year leap
    plan_fixed(KIND_DAY, 1, 0, 0, 0, 0, 0, 0);
    plan_fixed(KIND_LOAD, 0, 2100, 2, 28, 23, 59, 59);
    plan_fixed(KIND_SEC, 1, 0, 0, 0, 0, 0, 0);                  // ripples into March
    plan_fixed(KIND_LOAD, 0, 2001, 1, 31, 10, 20, 30);
    plan_fixed(KIND_MONTH, 1, 0, 0, 0, 0, 0, 0);                // stores February 31
    plan_fixed(KIND_DIFF, 0, 2001, 3, 3, 10, 20, 30);           // same position, other date
    plan_fixed(KIND_DIFF, 0, 2001, 3, 4, 0, 0, 0);              // counts on from over-long day
    plan_fixed(KIND_DAY, 0, 0, 0, 0, 0, 0, 0);                  // normalizes the day
    plan_fixed(KIND_DIFF, 0, 2001, 3, 3, 10, 20, 29);           // same date, a second early
    plan_fixed(KIND_SEC, 2 ** AMOUNT_W - 1, 0, 0, 0, 0, 0, 0);
    plan_fixed(KIND_MIN, 2 ** AMOUNT_W - 1, 0, 0, 0, 0, 0, 0);
    plan_fixed(KIND_HOUR, 2 ** AMOUNT_W - 1, 0, 0, 0, 0, 0, 0);
    plan_fixed(KIND_LOAD, 0, 1, 1, 1, 0, 0, 0);
    plan_fixed(KIND_DIFF, 0, MAX_YEAR, 12, 31, 23, 59, 59);     // largest elapsed count
    plan_fixed(KIND_MONTH, 12 * MAX_YEAR - 1, 0, 0, 0, 0, 0, 0);  // lands on the last month
    plan_fixed(KIND_MONTH, 1, 0, 0, 0, 0, 0, 0);
    plan_fixed(KIND_LOAD, 0, 1, 6, 15, 0, 0, 0);
    plan_fixed(KIND_YEAR, MAX_YEAR - 1, 0, 0, 0, 0, 0, 0);
    plan_fixed(KIND_YEAR, 1, 0, 0, 0, 0, 0, 0);

    for (int i = 0; i < RANDOM_REQUESTS; i++) plan_random_request();

    // hold reset, then release it
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // wait for the driver to empty its list and every result to come back
    while (queued_requests.size() != 0 || start || due_datetimes.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("ran %0d loads, %0d adds, %0d differences; %0d results checked, %0d with error",
             kind_seen[KIND_LOAD],
             kind_seen[KIND_SEC] + kind_seen[KIND_MIN] + kind_seen[KIND_HOUR] +
             kind_seen[KIND_DAY] + kind_seen[KIND_MONTH] + kind_seen[KIND_YEAR],
             kind_seen[KIND_DIFF], results_seen, errors_flagged);
    $display("over-long days stored %0d times, longest elapsed count %0d s, %0d mismatches",
             overlong_seen, longest_span, mismatches);
    if (mismatches == 0 && due_datetimes.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/cdt_pkg.sv
hw/rtl/cdt_div.sv
hw/rtl/cdt_walk.sv
hw/rtl/calendar_datetime_adder.sv
test/calendar_datetime_adder_tb.sv
